[rtl/cau_pkg.sv]
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic neg_re;
		logic neg_im;
		logic huge_re;
		logic huge_im;
		logic dz;
	} flags_t;

endpackage

[rtl/complex_arith_unit_core.sv]
// Complex arithmetic unit top level: add, subtract, multiply and divide in fixed point.
//
// An item is presented on opcode, a_re, a_im, b_re and b_im and is taken at a clock
// edge where start is high and busy is low. busy is always low: the pipeline takes
// one item in every cycle. Each item gives exactly one result on res_re, res_im,
// overflow and div_zero, shown for one cycle with done high; results leave in the
// order in which items came in.
// Every operation passes through the same stages. Four front stages form products,
// sums, magnitudes and the divisor; then one stage per quotient bit of the
// restoring divider; then one saturation stage.
// Multiply truncates toward zero; divide forms the conjugate product over |b|^2.
// Divide by zero gives zero with div_zero set. Saturated parts set overflow.
// Reset clears every valid bit, so no result appears until an item is taken.
// The receiver cannot stall the block, and the block never stalls itself.
module complex_arith_unit_core import cau_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        done,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic        overflow,
	output logic        div_zero
);
	localparam int W   = WORD_BITS;
	localparam int MW  = 2 * WORD_BITS;
	localparam int XW  = 3 * WORD_BITS + FRAC_BITS;
	localparam int LAT = WORD_BITS + 5;
	localparam logic [31:0] MAX_POS = 32'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic [31:0] MAX_NEG = 32'(-(64'sd1 <<< (W - 1)));

	flags_t        fl_p     [W+1];
	logic [MW-1:0] mag_re_p [W+1];
	logic [MW-1:0] mag_im_p [W+1];
	logic [XW-1:0] rem_re_p [W+1];
	logic [XW-1:0] rem_im_p [W+1];
	logic [MW-1:0] den_p    [W+1];
	logic [W-1:0]  q_re_p   [W+1];
	logic [W-1:0]  q_im_p   [W+1];

	assign busy = 1'b0;

	cau_front #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start && !busy),
		.opcode  (opcode),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.fl      (fl_p[0]),
		.mag_re  (mag_re_p[0]),
		.mag_im  (mag_im_p[0]),
		.rem_re  (rem_re_p[0]),
		.rem_im  (rem_im_p[0]),
		.den     (den_p[0])
	);

	assign q_re_p[0] = '0;
	assign q_im_p[0] = '0;

	for (genvar k = 0; k < W; k++) begin : g_div
		cau_div_stage #(
			.WORD_BITS(WORD_BITS),
			.FRAC_BITS(FRAC_BITS),
			.SHIFT    (W - 1 - k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.fl_in     (fl_p[k]),
			.mag_re_in (mag_re_p[k]),
			.mag_im_in (mag_im_p[k]),
			.rem_re_in (rem_re_p[k]),
			.rem_im_in (rem_im_p[k]),
			.den_in    (den_p[k]),
			.q_re_in   (q_re_p[k]),
			.q_im_in   (q_im_p[k]),
			.fl_out    (fl_p[k+1]),
			.mag_re_out(mag_re_p[k+1]),
			.mag_im_out(mag_im_p[k+1]),
			.rem_re_out(rem_re_p[k+1]),
			.rem_im_out(rem_im_p[k+1]),
			.den_out   (den_p[k+1]),
			.q_re_out  (q_re_p[k+1]),
			.q_im_out  (q_im_p[k+1])
		);
	end

	cau_sat #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_sat (
		.clk     (clk),
		.arst_n  (arst_n),
		.fl      (fl_p[W]),
		.mag_re  (mag_re_p[W]),
		.mag_im  (mag_im_p[W]),
		.q_re    (q_re_p[W]),
		.q_im    (q_im_p[W]),
		.done    (done),
		.res_re  (res_re),
		.res_im  (res_im),
		.overflow(overflow),
		.div_zero(div_zero)
	);

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("Result strobe without a matching item.");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_re == '0 && res_im == '0 && !overflow))
		else $error("Divide by zero result is not clean.");

	a_ovf_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (res_re == MAX_POS || res_re == MAX_NEG
			|| res_im == MAX_POS || res_im == MAX_NEG))
		else $error("Overflow raised without a saturated part.");

endmodule

[rtl/cau_front.sv]
// Front stages: products, sums, magnitudes and divider set-up.
module cau_front import cau_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [1:0]                 opcode,
	input  logic [31:0]                a_re,
	input  logic [31:0]                a_im,
	input  logic [31:0]                b_re,
	input  logic [31:0]                b_im,
	output flags_t                     fl,
	output logic [2*WORD_BITS-1:0]     mag_re,
	output logic [2*WORD_BITS-1:0]     mag_im,
	output logic [3*WORD_BITS+FRAC_BITS-1:0] rem_re,
	output logic [3*WORD_BITS+FRAC_BITS-1:0] rem_im,
	output logic [2*WORD_BITS-1:0]     den
);
	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int MW = 2 * W;
	localparam int VW = 2 * W + 1;
	localparam int XW = 3 * W + F;

	logic signed [W-1:0]  ar, ai, br, bi;
	logic signed [W:0]    sum_re, sum_im;
	op_t                  op_in;

	logic                 valid_s1;
	op_t                  op_s1;
	logic signed [MW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, d_rr_s1, d_ii_s1;
	logic signed [W:0]    sum_re_s1, sum_im_s1;

	logic                 valid_s2;
	op_t                  op_s2;
	logic signed [VW-1:0] v_re_s2, v_im_s2;
	logic [MW-1:0]        den_s2;
	logic signed [VW-1:0] v_re, v_im;
	logic signed [VW-1:0] neg_v_re, neg_v_im;

	logic                 valid_s3;
	op_t                  op_s3;
	logic                 neg_re_s3, neg_im_s3, dz_s3;
	logic [MW-1:0]        mag_re_s3, mag_im_s3, den_s3;

	logic                 valid_s4;
	op_t                  op_s4;
	logic                 neg_re_s4, neg_im_s4, dz_s4, huge_re_s4, huge_im_s4;
	logic [MW-1:0]        mag_re_s4, mag_im_s4, den_s4;
	logic [XW-1:0]        rem_re_s4, rem_im_s4;
	logic [XW-1:0]        n_re, n_im, den_top;

	assign op_in = op_t'(opcode);
	assign ar = $signed(a_re[W-1:0]);
	assign ai = $signed(a_im[W-1:0]);
	assign br = $signed(b_re[W-1:0]);
	assign bi = $signed(b_im[W-1:0]);

	always_comb begin
		if (op_in == OP_SUB) begin
			sum_re = (W+1)'(ar) - (W+1)'(br);
			sum_im = (W+1)'(ai) - (W+1)'(bi);
		end else begin
			sum_re = (W+1)'(ar) + (W+1)'(br);
			sum_im = (W+1)'(ai) + (W+1)'(bi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= op_in;
		p_rr_s1   <= ar * br;
		p_ii_s1   <= ai * bi;
		p_ri_s1   <= ar * bi;
		p_ir_s1   <= ai * br;
		d_rr_s1   <= br * br;
		d_ii_s1   <= bi * bi;
		sum_re_s1 <= sum_re;
		sum_im_s1 <= sum_im;
	end

	always_comb begin
		unique case (op_s1)
			OP_MUL: begin
				v_re = VW'(p_rr_s1) - VW'(p_ii_s1);
				v_im = VW'(p_ri_s1) + VW'(p_ir_s1);
			end
			OP_DIV: begin
				v_re = VW'(p_rr_s1) + VW'(p_ii_s1);
				v_im = VW'(p_ir_s1) - VW'(p_ri_s1);
			end
			default: begin
				v_re = VW'(sum_re_s1);
				v_im = VW'(sum_im_s1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		v_re_s2 <= v_re;
		v_im_s2 <= v_im;
		den_s2  <= d_rr_s1[MW-1:0] + d_ii_s1[MW-1:0];
	end

	assign neg_v_re = -v_re_s2;
	assign neg_v_im = -v_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		neg_re_s3 <= v_re_s2[VW-1];
		neg_im_s3 <= v_im_s2[VW-1];
		mag_re_s3 <= v_re_s2[VW-1] ? neg_v_re[MW-1:0] : v_re_s2[MW-1:0];
		mag_im_s3 <= v_im_s2[VW-1] ? neg_v_im[MW-1:0] : v_im_s2[MW-1:0];
		den_s3    <= den_s2;
		dz_s3     <= (op_s2 == OP_DIV) && (den_s2 == '0);
	end

	assign n_re    = XW'(mag_re_s3) << F;
	assign n_im    = XW'(mag_im_s3) << F;
	assign den_top = XW'(den_s3) << W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s4      <= op_s3;
		neg_re_s4  <= neg_re_s3;
		neg_im_s4  <= neg_im_s3;
		dz_s4      <= dz_s3;
		den_s4     <= den_s3;
		huge_re_s4 <= (n_re >= den_top);
		huge_im_s4 <= (n_im >= den_top);
		rem_re_s4  <= n_re;
		rem_im_s4  <= n_im;
		if (op_s3 == OP_MUL) begin
			mag_re_s4 <= mag_re_s3 >> F;
			mag_im_s4 <= mag_im_s3 >> F;
		end else begin
			mag_re_s4 <= mag_re_s3;
			mag_im_s4 <= mag_im_s3;
		end
	end

	always_comb begin
		fl.valid   = valid_s4;
		fl.op      = op_s4;
		fl.neg_re  = neg_re_s4;
		fl.neg_im  = neg_im_s4;
		fl.huge_re = huge_re_s4;
		fl.huge_im = huge_im_s4;
		fl.dz      = dz_s4;
	end

	assign mag_re = mag_re_s4;
	assign mag_im = mag_im_s4;
	assign rem_re = rem_re_s4;
	assign rem_im = rem_im_s4;
	assign den    = den_s4;

endmodule

[rtl/cau_div_stage.sv]
// One restoring division stage that settles one quotient bit of both parts of a divide item.
module cau_div_stage import cau_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	parameter int SHIFT     = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  flags_t                           fl_in,
	input  logic [2*WORD_BITS-1:0]           mag_re_in,
	input  logic [2*WORD_BITS-1:0]           mag_im_in,
	input  logic [3*WORD_BITS+FRAC_BITS-1:0] rem_re_in,
	input  logic [3*WORD_BITS+FRAC_BITS-1:0] rem_im_in,
	input  logic [2*WORD_BITS-1:0]           den_in,
	input  logic [WORD_BITS-1:0]             q_re_in,
	input  logic [WORD_BITS-1:0]             q_im_in,
	output flags_t                           fl_out,
	output logic [2*WORD_BITS-1:0]           mag_re_out,
	output logic [2*WORD_BITS-1:0]           mag_im_out,
	output logic [3*WORD_BITS+FRAC_BITS-1:0] rem_re_out,
	output logic [3*WORD_BITS+FRAC_BITS-1:0] rem_im_out,
	output logic [2*WORD_BITS-1:0]           den_out,
	output logic [WORD_BITS-1:0]             q_re_out,
	output logic [WORD_BITS-1:0]             q_im_out
);
	localparam int W  = WORD_BITS;
	localparam int XW = 3 * WORD_BITS + FRAC_BITS;

	logic [XW-1:0] dsh;
	logic [XW-1:0] rem_re_n, rem_im_n;
	logic [W-1:0]  q_re_n, q_im_n;
	flags_t        fl_q;

	assign dsh = XW'(den_in) << SHIFT;

	always_comb begin
		rem_re_n = rem_re_in;
		rem_im_n = rem_im_in;
		q_re_n   = q_re_in;
		q_im_n   = q_im_in;
		if (fl_in.op == OP_DIV) begin
			if (rem_re_in >= dsh) begin
				rem_re_n      = rem_re_in - dsh;
				q_re_n[SHIFT] = 1'b1;
			end
			if (rem_im_in >= dsh) begin
				rem_im_n      = rem_im_in - dsh;
				q_im_n[SHIFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
		end else begin
			fl_q <= fl_in;
		end
	end

	always_ff @(posedge clk) begin
		mag_re_out <= mag_re_in;
		mag_im_out <= mag_im_in;
		rem_re_out <= rem_re_n;
		rem_im_out <= rem_im_n;
		den_out    <= den_in;
		q_re_out   <= q_re_n;
		q_im_out   <= q_im_n;
	end

	assign fl_out = fl_q;

endmodule

[rtl/cau_sat.sv]
// Output stage: selects the result, saturates it and drives the result registers.
module cau_sat import cau_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  flags_t                 fl,
	input  logic [2*WORD_BITS-1:0] mag_re,
	input  logic [2*WORD_BITS-1:0] mag_im,
	input  logic [WORD_BITS-1:0]   q_re,
	input  logic [WORD_BITS-1:0]   q_im,
	output logic                   done,
	output logic [31:0]            res_re,
	output logic [31:0]            res_im,
	output logic                   overflow,
	output logic                   div_zero
);
	localparam int W  = WORD_BITS;
	localparam int MW = 2 * WORD_BITS;
	localparam int OW = WORD_BITS + 1 - FRAC_BITS + FRAC_BITS;

	logic          is_div;
	logic [MW-1:0] m_re, m_im;
	logic [OW-1:0] sr_re, sr_im;
	logic          done_q;
	logic [31:0]   res_re_q, res_im_q;
	logic          overflow_q, div_zero_q;

	function automatic logic [OW-1:0] sat_part(input logic neg, input logic [MW-1:0] m,
			input logic h);
		logic [MW-1:0] lim;
		logic [MW-1:0] mm;
		logic          o;
		lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
		o   = h || (m > lim);
		mm  = o ? lim : m;
		mm  = neg ? (MW'(0) - mm) : mm;
		return {o, mm[W-1:0]};
	endfunction

	assign is_div = (fl.op == OP_DIV);
	assign m_re   = is_div ? MW'(q_re) : mag_re;
	assign m_im   = is_div ? MW'(q_im) : mag_im;
	assign sr_re  = sat_part(fl.neg_re, m_re, is_div && fl.huge_re);
	assign sr_im  = sat_part(fl.neg_im, m_im, is_div && fl.huge_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fl.dz) begin
			res_re_q   <= '0;
			res_im_q   <= '0;
			overflow_q <= 1'b0;
			div_zero_q <= 1'b1;
		end else begin
			res_re_q   <= 32'($signed(sr_re[W-1:0]));
			res_im_q   <= 32'($signed(sr_im[W-1:0]));
			overflow_q <= sr_re[W] | sr_im[W];
			div_zero_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign res_re   = res_re_q;
	assign res_im   = res_im_q;
	assign overflow = overflow_q;
	assign div_zero = div_zero_q;

endmodule

[tb/sv/tb_complex_arith_unit_core.sv]
// Self-checking testbench for the complex arithmetic unit, with a built-in predictor.
module tb_complex_arith_unit_core;
	import cau_pkg::*;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
	} cplx_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [31:0] a_re;
	logic [31:0] a_im;
	logic [31:0] b_re;
	logic [31:0] b_im;
	logic        done;
	logic [31:0] res_re;
	logic [31:0] res_im;
	logic        overflow;
	logic        div_zero;

	cplx_result_t pending_results[$];
	int           error_count;
	int           idle_pct;

	complex_arith_unit_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .overflow(overflow), .div_zero(div_zero)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] saturate(input logic neg, input logic [127:0] mag,
			input logic huge, inout logic ovf);
		logic [127:0] m;
		m = mag;
		if (neg) begin
			if (huge || m > 128'h8000_0000) begin
				ovf = 1'b1;
				m = 128'h8000_0000;
			end
			return 32'(-m);
		end else begin
			if (huge || m > 128'h7FFF_FFFF) begin
				ovf = 1'b1;
				m = 128'h7FFF_FFFF;
			end
			return m[31:0];
		end
	endfunction

	function automatic logic [127:0] scaled_quotient(input logic [127:0] mag,
			input logic [127:0] den, output logic huge);
		huge = (mag / den) >= (128'd1 << 33);
		return huge ? 128'd0 : ((mag << 16) / den);
	endfunction

	function automatic cplx_result_t predict_cplx(input op_t op, input logic [31:0] xr,
			input logic [31:0] xi, input logic [31:0] yr, input logic [31:0] yi);
		cplx_result_t r;
		logic signed [127:0] ar, ai, br, bi, sr, si, den;
		logic [127:0] mr, mi;
		logic hr, hi;
		ar = 128'(signed'(xr));
		ai = 128'(signed'(xi));
		br = 128'(signed'(yr));
		bi = 128'(signed'(yi));
		hr = 1'b0;
		hi = 1'b0;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		case (op)
			OP_ADD: begin
				sr = ar + br;
				si = ai + bi;
			end
			OP_SUB: begin
				sr = ar - br;
				si = ai - bi;
			end
			OP_MUL: begin
				sr = ar * br - ai * bi;
				si = ar * bi + ai * br;
			end
			default: begin
				sr = ar * br + ai * bi;
				si = ai * br - ar * bi;
			end
		endcase
		mr = sr < 0 ? -sr : sr;
		mi = si < 0 ? -si : si;
		if (op == OP_MUL) begin
			mr = mr >> 16;
			mi = mi >> 16;
		end else if (op == OP_DIV) begin
			den = br * br + bi * bi;
			if (den == 0) begin
				r.re = '0;
				r.im = '0;
				r.dz = 1'b1;
				return r;
			end
			mr = scaled_quotient(mr, den, hr);
			mi = scaled_quotient(mi, den, hi);
		end
		r.re = saturate(sr < 0, mr, hr, r.ovf);
		r.im = saturate(si < 0, mi, hi, r.ovf);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	always @(posedge clk) begin
		cplx_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("done", 32'd1, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (res_re !== want.re) report_mismatch("res_re", res_re, want.re);
				if (res_im !== want.im) report_mismatch("res_im", res_im, want.im);
				if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
				if (div_zero !== want.dz) report_mismatch("div_zero", div_zero, want.dz);
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(predict_cplx(op_t'(opcode), a_re, a_im, b_re, b_im));
	end

	task automatic send_item(input op_t op, input logic [31:0] xr, input logic [31:0] xi,
			input logic [31:0] yr, input logic [31:0] yi);
		start <= 1'b1;
		opcode <= op;
		a_re <= xr;
		a_im <= xi;
		b_re <= yr;
		b_im <= yi;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3, 4: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
			5, 6: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] ext[4];
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
		for (int op = 0; op < 4; op++) begin
			send_item(op_t'(op), ext[0], ext[1], ext[1], ext[0]);
			send_item(op_t'(op), ext[1], ext[1], ext[1], ext[1]);
			send_item(op_t'(op), ext[0], ext[0], ext[0], ext[0]);
			send_item(op_t'(op), 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, ext[3]);
		end
		send_item(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
		send_item(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
		send_item(OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h0);
		send_item(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
		send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000);
	endtask

	task automatic test_random(input int count);
		op_t op;
		logic [31:0] yr, yi;
		for (int i = 0; i < count; i++) begin
			op = op_t'($urandom_range(3));
			yr = random_operand();
			yi = random_operand();
			if (op == OP_DIV && $urandom_range(19) == 0) begin
				yr = '0;
				yi = '0;
			end
			send_item(op, random_operand(), random_operand(), yr, yi);
		end
	endtask

	initial begin
		#(20 * 200000);
		$display("tb_complex_arith_unit_core: errors");
		$finish;
	end

	initial begin
		error_count = 0;
		idle_pct = 20;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = '0;
		a_re = '0;
		a_im = '0;
		b_re = '0;
		b_im = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(460);
		idle_pct = 74;
		test_random(460);
		idle_pct = 0;
		test_random(460);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("tb_complex_arith_unit_core: clean");
		else
			$display("tb_complex_arith_unit_core: errors");
		$finish;
	end
endmodule
